/* rtl/tmlr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tmlr_pkg;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_RESOLVE = 1'b1;

	localparam logic [31:0] BYPASS_MASK = 32'h0000_0012;
	localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;

	localparam logic [15:0] KEY_L0 = 16'h0220;
	localparam logic [15:0] KEY_L1 = 16'h0230;
	localparam logic [15:0] KEY_L2 = 16'h0231;
	localparam logic [15:0] KEY_L3 = 16'h0241;
	localparam logic [15:0] KEY_L4 = 16'h0320;
	localparam logic [15:0] KEY_L5 = 16'h0330;
	localparam logic [15:0] KEY_L6 = 16'h0331;

	localparam logic [3:0] CASE_NONE = 4'd8;

	// source codes in the layout table: 0..15 pick a word, then zero and one
	localparam logic [4:0] SRC_ZERO = 5'd16;
	localparam logic [4:0] SRC_ONE  = 5'd17;

	localparam logic [4:0] LAYOUT_TBL [0:7][0:15] = '{
		'{5'd0, 5'd4, 5'd16, 5'd8,  5'd1, 5'd5, 5'd16, 5'd9,
		  5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17},
		'{5'd0, 5'd4, 5'd16, 5'd8,  5'd1, 5'd5, 5'd16, 5'd9,
		  5'd2, 5'd6, 5'd16, 5'd10, 5'd16, 5'd16, 5'd16, 5'd17},
		'{5'd0, 5'd4, 5'd16, 5'd8,  5'd1, 5'd5, 5'd16, 5'd9,
		  5'd16, 5'd16, 5'd16, 5'd16, 5'd2, 5'd6, 5'd16, 5'd10},
		'{5'd0, 5'd4, 5'd16, 5'd8,  5'd1, 5'd5, 5'd16, 5'd9,
		  5'd2, 5'd6, 5'd16, 5'd10, 5'd3, 5'd7, 5'd16, 5'd11},
		'{5'd0, 5'd4, 5'd8, 5'd12,  5'd1, 5'd5, 5'd9, 5'd13,
		  5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17},
		'{5'd0, 5'd4, 5'd8, 5'd12,  5'd1, 5'd5, 5'd9, 5'd13,
		  5'd2, 5'd6, 5'd10, 5'd14, 5'd16, 5'd16, 5'd16, 5'd17},
		'{5'd0, 5'd4, 5'd8, 5'd12,  5'd1, 5'd5, 5'd9, 5'd13,
		  5'd16, 5'd16, 5'd16, 5'd16, 5'd2, 5'd6, 5'd10, 5'd14},
		'{5'd0, 5'd4, 5'd8, 5'd12,  5'd1, 5'd5, 5'd9, 5'd13,
		  5'd2, 5'd6, 5'd10, 5'd14, 5'd3, 5'd7, 5'd11, 5'd15}
	};

	typedef enum logic [1:0] {
		ST_BYPASS     = 2'd0,
		ST_DISABLED   = 2'd1,
		ST_WRITTEN    = 2'd2,
		ST_UNRESOLVED = 2'd3
	} status_t;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  stage;
		logic [3:0]  word_index;
		logic [31:0] word_value;
		logic [31:0] transform_flags;
		logic [31:0] coord_index;
	} req_beat_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] layout_key;
		logic [3:0]  layout_case;
		logic [3:0]  out_index;
		logic [31:0] out_value;
		logic        last;
	} rsp_beat_t;

	// request handed from the front end to the word sequencer
	typedef struct packed {
		logic        start;
		logic        single;
		status_t     status;
		logic [15:0] key;
		logic [3:0]  lcase;
		logic [1:0]  stage;
		logic        stage_ok;
	} job_t;

endpackage
`default_nettype wire

/* rtl/tmlr_store.sv */
`timescale 1ns / 1ps
`default_nettype none
module tmlr_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [31:0]   wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [31:0]   rd_data
);

	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/tmlr_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
module tmlr_seq #(
	parameter int AW = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tmlr_pkg::job_t    job,
	output logic                   busy,
	output logic                   rd_en,
	output logic      [AW-1:0]     rd_addr,
	input  wire logic [31:0]       rd_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output tmlr_pkg::rsp_beat_t    rsp
);

	logic                run_q;
	logic [3:0]          cnt_q;
	logic                single_q;
	tmlr_pkg::status_t   status_q;
	logic [15:0]         key_q;
	logic [3:0]          case_q;
	logic [1:0]          stage_q;
	logic                stage_ok_q;

	logic                v_s1;
	logic [3:0]          idx_s1;
	logic [4:0]          src_s1;
	logic                last_s1;

	logic                out_v_q;
	tmlr_pkg::rsp_beat_t out_q;

	logic                move;
	logic                issue;
	logic [4:0]          src;
	logic                issue_last;
	logic [31:0]         word;

	assign move       = v_s1 && (!out_v_q || !rsp_stall);
	assign issue      = run_q && (!v_s1 || move);
	assign src        = single_q ? tmlr_pkg::SRC_ZERO : tmlr_pkg::LAYOUT_TBL[case_q[2:0]][cnt_q];
	assign issue_last = single_q || (cnt_q == 4'd15);
	assign rd_en      = issue && !src[4] && stage_ok_q;
	assign rd_addr    = AW'({stage_q, src[3:0]});
	assign busy       = run_q || v_s1;

	always_comb begin
		case (src_s1)
			tmlr_pkg::SRC_ZERO: word = 32'd0;
			tmlr_pkg::SRC_ONE:  word = tmlr_pkg::ONE_BITS;
			default:            word = stage_ok_q ? rd_data : 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= 4'd0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (job.start) begin
				run_q <= 1'b1;
				cnt_q <= 4'd0;
			end else if (issue) begin
				cnt_q <= cnt_q + 4'd1;
				if (issue_last) begin
					run_q <= 1'b0;
				end
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (move) begin
				v_s1 <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job.start) begin
			single_q   <= job.single;
			status_q   <= job.status;
			key_q      <= job.key;
			case_q     <= job.lcase;
			stage_q    <= job.stage;
			stage_ok_q <= job.stage_ok;
		end
		if (issue) begin
			idx_s1  <= single_q ? 4'd0 : cnt_q;
			src_s1  <= src;
			last_s1 <= issue_last;
		end
		if (move) begin
			out_q.status      <= status_q;
			out_q.layout_key  <= key_q;
			out_q.layout_case <= case_q;
			out_q.out_index   <= idx_s1;
			out_q.out_value   <= word;
			out_q.last        <= last_s1;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

/* rtl/texture_matrix_layout_remap_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Texture matrix layout remap. A load beat (cmd 0) writes one word of a stage's
// 16-word source matrix and gives no result. A resolve beat (cmd 1) gives
// either one status beat (bypassed, disabled or unresolved key) or sixteen
// matrix beats, one per cycle while the output does not stall, as the single
// read port of the matrix store delivers one word a cycle. A resolve keeps the
// input stalled while its words are read, and longer while the output stalls;
// the next beat is taken once the last word has left the read stage, while
// that word may still wait in the output register. The store has no reset;
// reading a word that was never loaded gives an undefined value.
module texture_matrix_layout_remap_core #(
	parameter int STAGES = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire tmlr_pkg::req_beat_t   req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output tmlr_pkg::rsp_beat_t        rsp,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [31:0]           cfg_data
);

	localparam int DEPTH = STAGES * 16;
	localparam int AW    = $clog2(DEPTH);

	localparam logic CFG_SHADER_FLAGS = 1'b0;
	localparam logic CFG_COORD_SIZES  = 1'b1;

	logic [31:0]    shader_flags_q;
	logic [31:0]    coord_sizes_q;

	logic           accept;
	logic           busy;
	logic           stage_ok;
	logic [7:0]     size_byte;
	logic [7:0]     n;
	logic [11:0]    key_hi;
	logic [15:0]    key;
	logic [3:0]     lcase;
	tmlr_pkg::job_t job;

	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [31:0]    rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shader_flags_q <= 32'd0;
			coord_sizes_q  <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHADER_FLAGS: shader_flags_q <= cfg_data;
				CFG_COORD_SIZES:  coord_sizes_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign req_stall = busy;
	assign accept    = req_valid && !req_stall;
	assign stage_ok  = 32'(req.stage) < STAGES;

	always_comb begin
		case (req.coord_index[1:0])
			2'd0:    size_byte = coord_sizes_q[7:0];
			2'd1:    size_byte = coord_sizes_q[15:8];
			2'd2:    size_byte = coord_sizes_q[23:16];
			default: size_byte = coord_sizes_q[31:24];
		endcase
	end

	// texgen forces three components, an unset size counts as two
	assign n      = (|req.coord_index[31:16]) ? 8'd3
	              : ((size_byte == 8'd0) ? 8'd2 : size_byte);
	assign key_hi = {n, 4'd0} | {4'd0, req.transform_flags[7:0]};
	assign key    = {key_hi, 3'd0, req.transform_flags[8]};

	always_comb begin
		if (key > tmlr_pkg::KEY_L4) begin
			if (key == tmlr_pkg::KEY_L5)      lcase = 4'd5;
			else if (key == tmlr_pkg::KEY_L6) lcase = 4'd6;
			else                              lcase = 4'd7;
		end else if (key == tmlr_pkg::KEY_L4) lcase = 4'd4;
		else if (key == tmlr_pkg::KEY_L0)     lcase = 4'd0;
		else if (key == tmlr_pkg::KEY_L1)     lcase = 4'd1;
		else if (key == tmlr_pkg::KEY_L2)     lcase = 4'd2;
		else if (key == tmlr_pkg::KEY_L3)     lcase = 4'd3;
		else                                  lcase = tmlr_pkg::CASE_NONE;
	end

	always_comb begin
		job.start    = accept && (req.cmd == tmlr_pkg::CMD_RESOLVE);
		job.stage    = req.stage;
		job.stage_ok = stage_ok;
		if (|(shader_flags_q & tmlr_pkg::BYPASS_MASK)) begin
			job.single = 1'b1;
			job.status = tmlr_pkg::ST_BYPASS;
			job.key    = 16'd0;
			job.lcase  = 4'd0;
		end else if (req.transform_flags == 32'd0) begin
			job.single = 1'b1;
			job.status = tmlr_pkg::ST_DISABLED;
			job.key    = 16'd0;
			job.lcase  = 4'd0;
		end else if (lcase == tmlr_pkg::CASE_NONE) begin
			job.single = 1'b1;
			job.status = tmlr_pkg::ST_UNRESOLVED;
			job.key    = key;
			job.lcase  = lcase;
		end else begin
			job.single = 1'b0;
			job.status = tmlr_pkg::ST_WRITTEN;
			job.key    = key;
			job.lcase  = lcase;
		end
	end

	tmlr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && (req.cmd == tmlr_pkg::CMD_LOAD) && stage_ok),
		.wr_addr (AW'({req.stage, req.word_index})),
		.wr_data (req.word_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tmlr_seq #(
		.AW (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

/* test/texture_matrix_layout_remap_core_tb.sv */
`timescale 1ns / 1ps
module texture_matrix_layout_remap_core_tb;
	import tmlr_pkg::*;

	localparam logic REG_SHADER_FLAGS = 1'b0;
	localparam logic REG_COORD_SIZES  = 1'b1;
	localparam logic [31:0] SHADER_BYPASS = 32'h0000_0012;
	localparam logic [31:0] FLOAT_ONE     = 32'h3F80_0000;
	localparam logic [3:0]  NO_LAYOUT     = 4'd8;
	localparam byte unsigned PICK_ZERO = 8'd16;
	localparam byte unsigned PICK_ONE  = 8'd17;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_CAP      = 200;

	class layout_scoreboard;
		logic [31:0] source_words [64];
		logic [31:0] shader_flags;
		logic [31:0] coord_sizes;
		byte unsigned layout_src [8][16];
		rsp_beat_t due_beats [$];
		int errors;
		int loads;
		int resolves;
		int beats_by_status [4];

		function new();
			shader_flags = '0;
			coord_sizes = '0;
			errors = 0;
			loads = 0;
			resolves = 0;
			beats_by_status = '{0, 0, 0, 0};
			layout_src = '{
				'{0, 4, PICK_ZERO, 8, 1, 5, PICK_ZERO, 9,
				  PICK_ZERO, PICK_ZERO, PICK_ZERO, PICK_ZERO,
				  PICK_ZERO, PICK_ZERO, PICK_ZERO, PICK_ONE},
				'{0, 4, PICK_ZERO, 8, 1, 5, PICK_ZERO, 9,
				  2, 6, PICK_ZERO, 10, PICK_ZERO, PICK_ZERO, PICK_ZERO, PICK_ONE},
				'{0, 4, PICK_ZERO, 8, 1, 5, PICK_ZERO, 9,
				  PICK_ZERO, PICK_ZERO, PICK_ZERO, PICK_ZERO, 2, 6, PICK_ZERO, 10},
				'{0, 4, PICK_ZERO, 8, 1, 5, PICK_ZERO, 9,
				  2, 6, PICK_ZERO, 10, 3, 7, PICK_ZERO, 11},
				'{0, 4, 8, 12, 1, 5, 9, 13,
				  PICK_ZERO, PICK_ZERO, PICK_ZERO, PICK_ZERO,
				  PICK_ZERO, PICK_ZERO, PICK_ZERO, PICK_ONE},
				'{0, 4, 8, 12, 1, 5, 9, 13,
				  2, 6, 10, 14, PICK_ZERO, PICK_ZERO, PICK_ZERO, PICK_ONE},
				'{0, 4, 8, 12, 1, 5, 9, 13,
				  PICK_ZERO, PICK_ZERO, PICK_ZERO, PICK_ZERO, 2, 6, 10, 14},
				'{0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15}
			};
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == REG_SHADER_FLAGS) begin
				shader_flags = val;
			end else begin
				coord_sizes = val;
			end
		endfunction

		// status, key and layout of a resolve under the current registers
		function void resolve_outcome(req_beat_t r, output status_t st,
				output logic [15:0] key, output logic [3:0] lc);
			logic [31:0] n;
			logic [31:0] k32;
			key = '0;
			lc = '0;
			if (|(shader_flags & SHADER_BYPASS)) begin
				st = ST_BYPASS;
			end else if (r.transform_flags == 32'h0) begin
				st = ST_DISABLED;
			end else begin
				if (|r.coord_index[31:16]) begin
					n = 32'd3;
				end else begin
					n = (coord_sizes >> (32'(r.coord_index[1:0]) * 8)) & 32'hFF;
					if (n == 32'd0) n = 32'd2;
				end
				// count and flags byte overlap on purpose: they are or-ed
				k32 = (((n << 4) | (r.transform_flags & 32'hFF)) << 4)
					| ((r.transform_flags >> 8) & 32'h1);
				key = k32[15:0];
				st = ST_WRITTEN;
				if (key > 16'h0320) begin
					lc = (key == 16'h0330) ? 4'd5 : (key == 16'h0331) ? 4'd6 : 4'd7;
				end else begin
					case (key)
						16'h0320: lc = 4'd4;
						16'h0220: lc = 4'd0;
						16'h0230: lc = 4'd1;
						16'h0231: lc = 4'd2;
						16'h0241: lc = 4'd3;
						default: begin
							st = ST_UNRESOLVED;
							lc = NO_LAYOUT;
						end
					endcase
				end
			end
		endfunction

		function void note_request(req_beat_t r);
			rsp_beat_t b;
			status_t st;
			logic [15:0] key;
			logic [3:0] lc;
			byte unsigned src;
			if (r.cmd == CMD_LOAD) begin
				source_words[{r.stage, r.word_index}] = r.word_value;
				loads++;
			end else begin
				resolves++;
				resolve_outcome(r, st, key, lc);
				b.status = st;
				b.layout_key = key;
				b.layout_case = lc;
				if (st != ST_WRITTEN) begin
					b.out_index = '0;
					b.out_value = '0;
					b.last = 1'b1;
					due_beats.push_back(b);
				end else begin
					for (int i = 0; i < 16; i++) begin
						src = layout_src[lc][i];
						b.out_index = 4'(i);
						if (src == PICK_ZERO) b.out_value = '0;
						else if (src == PICK_ONE) b.out_value = FLOAT_ONE;
						else b.out_value = source_words[{r.stage, 4'(src)}];
						b.last = (i == 15);
						due_beats.push_back(b);
					end
				end
			end
		endfunction

		function void cmp(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t: %s expected %h got %h", $time, field, want, got);
			end
		endfunction

		function void check_beat(rsp_beat_t got);
			rsp_beat_t want;
			if (due_beats.size() == 0) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t: beat with nothing expected, expected none got %h",
						$time, got);
			end else begin
				want = due_beats.pop_front();
				cmp("status", 32'(want.status), 32'(got.status));
				cmp("layout_key", 32'(want.layout_key), 32'(got.layout_key));
				cmp("layout_case", 32'(want.layout_case), 32'(got.layout_case));
				cmp("out_index", 32'(want.out_index), 32'(got.out_index));
				cmp("out_value", want.out_value, got.out_value);
				cmp("last", 32'(want.last), 32'(got.last));
				if (!$isunknown(got.status)) beats_by_status[got.status]++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_beat_t req_in = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_beat_t rsp_out;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	layout_scoreboard sb;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int quiet_cycles = 0;
	bit [15:0] loaded [4] = '{16'h0, 16'h0, 16'h0, 16'h0};

	texture_matrix_layout_remap_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req_in),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		rsp_stall = (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) sb.note_request(req_in);
		if (arst_n && rsp_valid && !rsp_stall) sb.check_beat(rsp_out);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic req_beat_t mk(logic c, logic [1:0] s, logic [3:0] wi,
			logic [31:0] wv, logic [31:0] fl, logic [31:0] ci);
		req_beat_t r;
		r.cmd = c;
		r.stage = s;
		r.word_index = wi;
		r.word_value = wv;
		r.transform_flags = fl;
		r.coord_index = ci;
		return r;
	endfunction

	function automatic req_beat_t rand_load();
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = 32'h0;
			1: v = 32'hFFFF_FFFF;
			default: v = $urandom;
		endcase
		return mk(CMD_LOAD, 2'($urandom), 4'($urandom), v, $urandom, $urandom);
	endfunction

	// mostly counts and sizes that land on a layout, some noise
	function automatic req_beat_t rand_resolve();
		logic [31:0] fl;
		logic [31:0] ci;
		logic [7:0] cnt;
		logic [22:0] hi;
		int k;
		k = $urandom_range(99);
		case ($urandom_range(2))
			0: cnt = 8'h20;
			1: cnt = 8'h30;
			default: cnt = 8'h40;
		endcase
		hi = ($urandom_range(3) == 0) ? 23'($urandom) : 23'h0;
		if (k < 8) fl = 32'h0;
		else if (k < 18) fl = $urandom;
		else fl = {hi, 1'($urandom_range(1)), cnt};
		k = $urandom_range(99);
		if (k < 35) ci = {16'($urandom_range(16'hFFFF, 1)), 16'($urandom)};
		else if (k < 45) ci = $urandom;
		else ci = {16'h0, 16'($urandom)};
		return mk(CMD_RESOLVE, 2'($urandom), 4'($urandom), $urandom, fl, ci);
	endfunction

	function automatic logic [31:0] rand_sizes();
		logic [31:0] v;
		for (int j = 0; j < 4; j++) begin
			case ($urandom_range(4))
				0: v[j*8 +: 8] = 8'd0;
				1: v[j*8 +: 8] = 8'd2;
				2: v[j*8 +: 8] = 8'd3;
				3: v[j*8 +: 8] = 8'd4;
				default: v[j*8 +: 8] = 8'($urandom);
			endcase
		end
		return v;
	endfunction

	task automatic send_beat(req_beat_t b);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_in = b;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		if (b.cmd == CMD_LOAD) loaded[b.stage][b.word_index] = 1'b1;
	endtask

	// never let a resolve read a store word that was not loaded
	task automatic send_resolve(req_beat_t r);
		status_t st;
		logic [15:0] key;
		logic [3:0] lc;
		byte unsigned src;
		sb.resolve_outcome(r, st, key, lc);
		if (st == ST_WRITTEN) begin
			for (int i = 0; i < 16; i++) begin
				src = sb.layout_src[lc][i];
				if (src < PICK_ZERO && !loaded[r.stage][4'(src)])
					send_beat(mk(CMD_LOAD, r.stage, 4'(src), $urandom, 32'h0, 32'h0));
			end
		end
		send_beat(r);
	endtask

	task automatic settle();
		@(negedge clk);
		req_valid = 1'b0;
		while (sb.due_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [31:0] shader, logic [31:0] sizes);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = REG_SHADER_FLAGS;
		cfg_data = shader;
		@(negedge clk);
		cfg_index = REG_COORD_SIZES;
		cfg_data = sizes;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(REG_SHADER_FLAGS, shader);
		sb.set_reg(REG_COORD_SIZES, sizes);
	endtask

	initial begin
		logic [31:0] sf;
		logic [31:0] cs;
		int count;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// byte 3 of the sizes gives a count of four for texcoord set 3
		write_regs(32'h0, 32'h0400_0000);
		send_beat(mk(CMD_LOAD, 2'd0, 4'd0, 32'h0, 32'h0, 32'h0));
		send_beat(mk(CMD_LOAD, 2'd3, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_resolve(mk(CMD_RESOLVE, 2'd0, 4'd0, 32'h0, 32'h0, 32'h0));
		send_resolve(mk(CMD_RESOLVE, 2'd1, 4'd0, 32'h0, 32'h10, 32'h0));
		send_resolve(mk(CMD_RESOLVE, 2'd0, 4'd0, 32'h0, 32'h20, 32'h0));
		send_resolve(mk(CMD_RESOLVE, 2'd1, 4'd0, 32'h0, 32'h30, 32'h0));
		send_resolve(mk(CMD_RESOLVE, 2'd2, 4'd0, 32'h0, 32'h130, 32'h0));
		send_resolve(mk(CMD_RESOLVE, 2'd3, 4'd0, 32'h0, 32'h140, 32'h0));
		send_resolve(mk(CMD_RESOLVE, 2'd0, 4'd0, 32'h0, 32'h20, 32'h0001_0000));
		send_resolve(mk(CMD_RESOLVE, 2'd1, 4'd0, 32'h0, 32'h30, 32'hFFFF_0000));
		send_resolve(mk(CMD_RESOLVE, 2'd2, 4'd0, 32'h0, 32'h130, 32'h0001_0002));
		send_resolve(mk(CMD_RESOLVE, 2'd3, 4'd0, 32'h0, 32'h40, 32'h3));
		send_resolve(mk(CMD_RESOLVE, 2'd3, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		// nonzero flags with a zero count byte
		send_resolve(mk(CMD_RESOLVE, 2'd0, 4'd0, 32'h0, 32'h100, 32'h0));
		send_resolve(mk(CMD_RESOLVE, 2'd1, 4'd0, 32'h0, 32'h120, 32'h0001_0000));
		send_resolve(mk(CMD_RESOLVE, 2'd2, 4'd0, 32'h0, 32'h40, 32'h0));
		send_resolve(mk(CMD_RESOLVE, 2'd2, 4'd0, 32'h0, 32'h30, 32'h0000_FFFF));
		settle();
		write_regs(32'h10, 32'h0);
		send_resolve(mk(CMD_RESOLVE, 2'd1, 4'd0, 32'h0, 32'h20, 32'h0));
		send_beat(mk(CMD_LOAD, 2'd2, 4'd7, 32'h8000_0001, 32'h0, 32'h0));
		settle();

		for (int p = 0; p < 8; p++) begin
			count = 55;
			case (p)
				4: begin
					sf = 32'hFFFF_FFFF;
					cs = 32'hFFFF_FFFF;
					count = 20;
				end
				5: begin
					sf = ~SHADER_BYPASS;
					cs = 32'hFFFF_FFFF;
				end
				6: begin
					sf = 32'h0;
					cs = 32'h0;
				end
				7: begin
					sf = $urandom | ($urandom_range(1) ? 32'h2 : 32'h10);
					cs = rand_sizes();
					count = 20;
				end
				default: begin
					sf = $urandom & ~SHADER_BYPASS;
					cs = rand_sizes();
				end
			endcase
			write_regs(sf, cs);
			case (p % 4)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 76; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 76; end
				default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
			endcase
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(99) < 25) send_beat(rand_load());
				else send_resolve(rand_resolve());
			end
			settle();
		end

		$display("covered %0d loads and %0d resolves over 10 register settings",
			sb.loads, sb.resolves);
		$display("result beats: %0d bypassed, %0d disabled, %0d matrix, %0d unresolved",
			sb.beats_by_status[ST_BYPASS], sb.beats_by_status[ST_DISABLED],
			sb.beats_by_status[ST_WRITTEN], sb.beats_by_status[ST_UNRESOLVED]);
		if (sb.errors == 0 && sb.due_beats.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
